/* rtl/bpws_pkg.sv */
package bpws_pkg;

  // Fixed-point scale: radii carry 8 fraction bits (radius = isqrt(d^2 << 16) / 2).
  localparam int RAD_SHIFT    = 16;
  localparam int CTR_SHIFT    = 14;
  // Extra root bits beyond the coordinate width.
  localparam int ROOT_GUARD   = 9;
  localparam int FACTOR_WIDTH = 8;

  typedef logic [FACTOR_WIDTH-1:0] factor_t;

  localparam factor_t FACTOR_RESET = factor_t'(2);

endpackage

/* rtl/bpws_if.sv */
interface bpws_box_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] first_min_x;
  logic signed [W-1:0] first_min_y;
  logic signed [W-1:0] first_max_x;
  logic signed [W-1:0] first_max_y;
  logic signed [W-1:0] second_min_x;
  logic signed [W-1:0] second_min_y;
  logic signed [W-1:0] second_max_x;
  logic signed [W-1:0] second_max_y;

  modport source (
    output valid, first_min_x, first_min_y, first_max_x, first_max_y,
    output second_min_x, second_min_y, second_max_x, second_max_y,
    input  ready
  );
  modport sink (
    input  valid, first_min_x, first_min_y, first_max_x, first_max_y,
    input  second_min_x, second_min_y, second_max_x, second_max_y,
    output ready
  );
endinterface

interface bpws_sep_if;
  logic valid;
  logic ready;
  logic well_separated;

  modport source (output valid, well_separated, input ready);
  modport sink   (input valid, well_separated, output ready);
endinterface

/* rtl/bpws_front.sv */
module bpws_front #(
  parameter int W  = 16,
  parameter int RW = W + 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  logic signed [W-1:0] umnx,
  input  logic signed [W-1:0] umny,
  input  logic signed [W-1:0] umxx,
  input  logic signed [W-1:0] umxy,
  input  logic signed [W-1:0] vmnx,
  input  logic signed [W-1:0] vmny,
  input  logic signed [W-1:0] vmxx,
  input  logic signed [W-1:0] vmxy,
  output logic                rad_valid,
  output logic [2*RW-1:0]     rad_u,
  output logic [2*RW-1:0]     rad_v,
  output logic [2*RW-1:0]     rad_c
);

  // Stage 1: side widths and doubled center offsets.
  logic              v1;
  logic signed [W:0]   wux, wuy, wvx, wvy;
  logic signed [W+1:0] cx, cy;
  // Stage 2: magnitudes.
  logic              v2;
  logic [W-1:0]      mux, muy, mvx, mvy;
  logic [W:0]        mcx, mcy;
  // Stage 3: squares.
  logic              v3;
  logic [2*W-1:0]    sux, suy, svx, svy;
  logic [2*W+1:0]    scx, scy;
  // Stage 4: sums, scaled into the radicands.
  logic              v4;
  logic [2*W:0]      su, sv;
  logic [2*W+2:0]    sc;

  function automatic logic signed [W:0] sx1(input logic signed [W-1:0] a);
    sx1 = $signed({a[W-1], a});
  endfunction

  function automatic logic signed [W+1:0] sx2(input logic signed [W-1:0] a);
    sx2 = $signed({a[W-1], a[W-1], a});
  endfunction

  function automatic logic [W-1:0] absw(input logic signed [W:0] a);
    logic signed [W:0] n;
    n = -a;
    absw = a[W] ? n[W-1:0] : a[W-1:0];
  endfunction

  function automatic logic [W:0] absc(input logic signed [W+1:0] a);
    logic signed [W+1:0] n;
    n = -a;
    absc = a[W+1] ? n[W:0] : a[W:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wux <= sx1(umxx) - sx1(umnx);
      wuy <= sx1(umxy) - sx1(umny);
      wvx <= sx1(vmxx) - sx1(vmnx);
      wvy <= sx1(vmxy) - sx1(vmny);
      cx  <= (sx2(umxx) + sx2(umnx)) - (sx2(vmxx) + sx2(vmnx));
      cy  <= (sx2(umxy) + sx2(umny)) - (sx2(vmxy) + sx2(vmny));

      mux <= absw(wux);
      muy <= absw(wuy);
      mvx <= absw(wvx);
      mvy <= absw(wvy);
      mcx <= absc(cx);
      mcy <= absc(cy);

      sux <= mux * mux;
      suy <= muy * muy;
      svx <= mvx * mvx;
      svy <= mvy * mvy;
      scx <= mcx * mcx;
      scy <= mcy * mcy;

      su <= {1'b0, sux} + {1'b0, suy};
      sv <= {1'b0, svx} + {1'b0, svy};
      sc <= {1'b0, scx} + {1'b0, scy};
    end
  end

  assign rad_valid = v4;
  assign rad_u = {1'b0, su, {bpws_pkg::RAD_SHIFT{1'b0}}};
  assign rad_v = {1'b0, sv, {bpws_pkg::RAD_SHIFT{1'b0}}};
  assign rad_c = {1'b0, sc, {bpws_pkg::CTR_SHIFT{1'b0}}};

endmodule

/* rtl/bpws_sqrt.sv */
module bpws_sqrt #(
  parameter int RW = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  output logic            out_valid,
  output logic [RW-1:0]   root
);

  // One root bit per stage, two radicand bits consumed per stage.
  logic            vld_q  [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic            vld_c;
    logic [2*RW-1:0] rad_c;
    logic [RW:0]     rem_c;
    logic [RW-1:0]   root_c;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (i == 0) begin : g_head
      assign vld_c  = in_valid;
      assign rad_c  = rad;
      assign rem_c  = '0;
      assign root_c = '0;
    end else begin : g_body
      assign vld_c  = vld_q[i-1];
      assign rad_c  = rad_q[i-1];
      assign rem_c  = rem_q[i-1];
      assign root_c = root_q[i-1];
    end

    assign rem_sh = {rem_c, rad_c[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_c, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (advance) begin
        vld_q[i] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rad_q[i]  <= {rad_c[2*RW-3:0], 2'b00};
        rem_q[i]  <= diff[RW:0];
        root_q[i] <= {root_c[RW-2:0], ge};
      end
    end
  end

  assign out_valid = vld_q[RW-1];
  assign root      = root_q[RW-1];

endmodule

/* rtl/bpws_back.sv */
module bpws_back #(
  parameter int RW = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  logic [RW-1:0]     ru,
  input  logic [RW-1:0]     rv,
  input  logic [RW-1:0]     rc,
  input  bpws_pkg::factor_t factor,
  output logic              out_valid,
  output logic              well_separated
);

  localparam int FW = bpws_pkg::FACTOR_WIDTH;
  localparam int CW = RW + FW + 2;

  logic                 va, vb;
  logic [RW-1:0]        big;
  logic signed [RW+2:0] lhs_a, lhs_b;
  logic [RW+FW-1:0]     rhs;
  logic signed [CW-1:0] lhs_x, rhs_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  assign lhs_x = CW'(lhs_b);
  assign rhs_x = $signed({2'b00, rhs});

  always_ff @(posedge clk) begin
    if (advance) begin
      big   <= (ru > rv) ? ru : rv;
      lhs_a <= $signed({2'b00, rc, 1'b0}) - $signed({3'b000, ru}) - $signed({3'b000, rv});
      rhs   <= factor * big;
      lhs_b <= lhs_a;
      well_separated <= lhs_x >= rhs_x;
    end
  end

endmodule

/* rtl/box_pair_well_separated_test.sv */
// Channel   Dir  Payload                                         Beat taken when
// boxes     in   first/second min/max x/y, COORD_WIDTH signed     valid && ready
// verdict   out  well_separated, 1 bit                            valid && ready
// cfg       in   separation_factor, 8 bit unsigned                cfg_we high
//
// One box pair per cycle sustained while verdict is not stalled.
// The square-root pipelines hold most of the stages: one root bit per stage, COORD_WIDTH + 9 bits.
// rst is synchronous: it clears every valid bit and loads the factor with 2.
// A stall on verdict freezes the whole pipeline in place; boxes.ready drops with it.
module box_pair_well_separated_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  bpws_box_if.sink                    boxes,
  bpws_sep_if.source                  verdict,
  input  logic                        cfg_we,
  input  logic [bpws_pkg::FACTOR_WIDTH-1:0] cfg_wdata
);

  localparam int W  = COORD_WIDTH;
  localparam int RW = W + bpws_pkg::ROOT_GUARD;

  logic              advance;
  bpws_pkg::factor_t factor;
  logic              rad_valid;
  logic [2*RW-1:0]   rad_u, rad_v, rad_c;
  logic              vld_u, vld_v, vld_c;
  logic [RW-1:0]     ru, rv, rc;

  // Advance every stage together whenever the output slot is free or being drained.
  assign advance     = !verdict.valid || verdict.ready;
  assign boxes.ready = advance;

  // Hold the separation factor; the user must write it only while the pipe is empty (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= bpws_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      factor <= cfg_wdata;
    end
  end

  // Widths, offsets, squares and sums: four stages.
  bpws_front #(.W(W), .RW(RW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (boxes.valid),
    .umnx     (boxes.first_min_x),
    .umny     (boxes.first_min_y),
    .umxx     (boxes.first_max_x),
    .umxy     (boxes.first_max_y),
    .vmnx     (boxes.second_min_x),
    .vmny     (boxes.second_min_y),
    .vmxx     (boxes.second_max_x),
    .vmxy     (boxes.second_max_y),
    .rad_valid(rad_valid),
    .rad_u    (rad_u),
    .rad_v    (rad_v),
    .rad_c    (rad_c)
  );

  // Three parallel root pipelines, one per radius.
  bpws_sqrt #(.RW(RW)) u_sqrt_u (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(rad_valid),
    .rad(rad_u), .out_valid(vld_u), .root(ru)
  );
  bpws_sqrt #(.RW(RW)) u_sqrt_v (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(rad_valid),
    .rad(rad_v), .out_valid(vld_v), .root(rv)
  );
  bpws_sqrt #(.RW(RW)) u_sqrt_c (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(rad_valid),
    .rad(rad_c), .out_valid(vld_c), .root(rc)
  );

  // Gap, scaled larger radius and the compare; the last stage is the output register.
  bpws_back #(.RW(RW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (vld_u && vld_v && vld_c),
    .ru            (ru),
    .rv            (rv),
    .rc            (rc),
    .factor        (factor),
    .out_valid     (verdict.valid),
    .well_separated(verdict.well_separated)
  );

`ifndef ASSERT_OFF
  // The three root lanes share one control and must never drift apart.
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (vld_u == vld_v) && (vld_v == vld_c))
    else $error("root lanes out of step");

  // Reset empties the pipe: no verdict in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !verdict.valid)
    else $error("verdict valid right after reset");

  // While stalled the input side must also be held off.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (verdict.valid && !verdict.ready) |-> !boxes.ready)
    else $error("input taken during output stall");
`endif

endmodule
